### rtl/rsbt_pkg.sv
// ----------------------------------------------------------------------------
// rsbt_pkg : shared definitions for the run-length sprite blitter
// Register indexes, request kinds, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package rsbt_pkg;

   // defaults for the top-level parameters
   localparam int DEF_LINE_PITCH = 768;
   localparam int DEF_ADDR_BITS  = 20;

   // fixed field widths
   localparam int BYTE_BITS   = 8;
   localparam int OUT_ADDR_W  = 20;
   localparam int ROW_BITS    = 11;
   localparam int RUN_BITS    = 7;
   localparam int START_W     = 20;
   localparam int WIDTH_W     = 10;
   localparam int CLIP_W      = 21;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 3;
   localparam int PAL_DEPTH   = 256;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_START_ADDRESS    = 3'd0,
      REG_SPRITE_WIDTH     = 3'd1,
      REG_TRANSLATE_ENABLE = 3'd2,
      REG_CLIP_LOW         = 3'd3,
      REG_CLIP_HIGH        = 3'd4
   } csr_index_type;

   // request kinds carried on tuser
   typedef enum logic {
      REQ_STREAM = 1'b0,
      REQ_TABLE  = 1'b1
   } req_kind_type;

   // reset values of the configuration registers
   localparam logic [START_W-1:0] RST_START_ADDRESS = '0;
   localparam logic [WIDTH_W-1:0] RST_SPRITE_WIDTH  = 10'd1;
   localparam logic [CLIP_W-1:0]  RST_CLIP_LOW      = '0;
   localparam logic [CLIP_W-1:0]  RST_CLIP_HIGH     = 21'd1048576;

endpackage

### rtl/rle_sprite_blit_translate_top.sv
// ----------------------------------------------------------------------------
// Pipeline: a stream byte goes to stage one (stepped state, palette read), then
// stage two (output). Throughput: one item per cycle unless rsp_tready stalls;
// the palette RAM read port sets the pipeline.
// Reset: synchronous, clears registers, pipeline valids and frame tracking.
// The palette table has no reset and holds garbage until written.
// ----------------------------------------------------------------------------
// rle_sprite_blit_translate_top : run-length transparent sprite blitter
// Decodes control and pixel bytes into pixel writes with clipping and an
// optional palette translation through a 256-entry table.
// ----------------------------------------------------------------------------
module rle_sprite_blit_translate_top
   import rsbt_pkg::*;
#(
   parameter int LINE_PITCH = DEF_LINE_PITCH,
   parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration write port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [23:0]            req_tdata,  // stream_byte, table_index, table_value
   input  logic                   req_tuser,  // req_type
   input  logic                   req_tlast,  // last_byte
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,  // write_addr, pixel, zero pad
   output logic                   rsp_tuser,  // write_valid
   output logic                   rsp_tlast   // frame_done
);

   // pointer carries two guard bits so that addresses below zero wrap high
   localparam int PTR_BITS = ADDR_BITS + 2;
   localparam int CMP_BITS = (PTR_BITS > CLIP_W) ? PTR_BITS : CLIP_W;
   localparam int PAL_AW   = $clog2(PAL_DEPTH);

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [START_W-1:0] start_address_ff;
   logic [WIDTH_W-1:0] sprite_width_ff;
   logic               translate_enable_ff;
   logic [CLIP_W-1:0]  clip_low_ff;
   logic [CLIP_W-1:0]  clip_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff    <= RST_START_ADDRESS;
         sprite_width_ff     <= RST_SPRITE_WIDTH;
         translate_enable_ff <= 1'b0;
         clip_low_ff         <= RST_CLIP_LOW;
         clip_high_ff        <= RST_CLIP_HIGH;
      end else if (csr_we) begin
         case (csr_index)
            REG_START_ADDRESS:    start_address_ff    <= csr_wdata[START_W-1:0];
            REG_SPRITE_WIDTH:     sprite_width_ff     <= csr_wdata[WIDTH_W-1:0];
            REG_TRANSLATE_ENABLE: translate_enable_ff <= csr_wdata[0];
            REG_CLIP_LOW:         clip_low_ff         <= csr_wdata[CLIP_W-1:0];
            REG_CLIP_HIGH:        clip_high_ff        <= csr_wdata[CLIP_W-1:0];
            default: ;  // writes outside the register list are dropped
         endcase
      end
   end

   // ------------------------------------------------------------------
   // request fields and handshake
   // ------------------------------------------------------------------
   logic [BYTE_BITS-1:0] req_byte;
   logic [BYTE_BITS-1:0] req_table_index;
   logic [BYTE_BITS-1:0] req_table_value;
   logic                 req_accept;
   logic                 stream_accept;
   logic                 table_accept;

   assign req_byte        = req_tdata[7:0];
   assign req_table_index = req_tdata[15:8];
   assign req_table_value = req_tdata[23:16];

   // stage one and stage two valids
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic out_free;
   logic s1_move;

   // stage two takes a new transfer once the held result has gone
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;

   assign req_accept    = req_tvalid && req_tready;
   assign stream_accept = req_accept && (req_tuser == REQ_STREAM);
   assign table_accept  = req_accept && (req_tuser == REQ_TABLE);

   // ------------------------------------------------------------------
   // decoder state
   // ------------------------------------------------------------------
   logic [PTR_BITS-1:0] ptr_ff,   ptr_in;
   logic [ROW_BITS-1:0] row_ff,   row_in;
   logic [RUN_BITS-1:0] run_ff,   run_in;
   logic                vis_ff,   vis_in;
   logic                fstart_ff, fstart_in;

   // stepped result of the accepted byte, captured into stage one
   logic                  step_wv;
   logic [OUT_ADDR_W-1:0] step_addr;

   always_comb begin
      logic [PTR_BITS-1:0]  ptr0;
      logic [ROW_BITS-1:0]  row0;
      logic [RUN_BITS-1:0]  run0;
      logic                 vis0;
      logic [PTR_BITS-1:0]  ptr1;
      logic [ROW_BITS-1:0]  row1;
      logic [RUN_BITS-1:0]  run1;
      logic                 vis1;
      logic [BYTE_BITS-1:0] skip;
      logic [CMP_BITS-1:0]  ptr_cmp;
      logic [ROW_BITS-1:0]  width_row;

      width_row = ROW_BITS'(sprite_width_ff);

      // a frame's first byte reloads pointer and row, and clears the run
      if (fstart_ff) begin
         ptr0 = PTR_BITS'(start_address_ff);
         row0 = width_row;
         run0 = '0;
         vis0 = 1'b0;
      end else begin
         ptr0 = ptr_ff;
         row0 = row_ff;
         run0 = run_ff;
         vis0 = vis_ff;
      end

      ptr_cmp   = CMP_BITS'(ptr0);
      skip      = BYTE_BITS'(-req_byte);  // magnitude of a negative control byte
      step_wv   = 1'b0;
      step_addr = OUT_ADDR_W'(ptr0[ADDR_BITS-1:0]);

      if (run0 != '0) begin
         // pixel byte inside a literal run
         step_wv = vis0;
         ptr1    = ptr0 + PTR_BITS'(1);
         run1    = run0 - RUN_BITS'(1);
         row1    = row0;
         vis1    = vis0;
      end else if (!req_byte[BYTE_BITS-1]) begin
         // open a literal run, clip-tested on its first address
         ptr1 = ptr0;
         run1 = req_byte[RUN_BITS-1:0];
         row1 = row0 - ROW_BITS'(req_byte);
         vis1 = (ptr_cmp >= CMP_BITS'(clip_low_ff)) && (ptr_cmp < CMP_BITS'(clip_high_ff));
      end else begin
         // transparent skip
         ptr1 = ptr0 + PTR_BITS'(skip);
         run1 = '0;
         row1 = row0 - ROW_BITS'(skip);
         vis1 = vis0;
      end

      if (!step_wv) begin
         step_addr = '0;
      end

      // row end: move up one line and reload the row counter
      ptr_in = ptr1;
      row_in = row1;
      if ((run1 == '0) && (row1 == '0)) begin
         ptr_in = ptr1 - PTR_BITS'(LINE_PITCH) - PTR_BITS'(sprite_width_ff);
         row_in = width_row;
      end

      run_in    = run1;
      vis_in    = vis1;
      fstart_in = 1'b0;
      // frame end: drop any unfinished run
      if (req_tlast) begin
         run_in    = '0;
         vis_in    = 1'b0;
         fstart_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         row_ff    <= ROW_BITS'(RST_SPRITE_WIDTH);
         run_ff    <= '0;
         vis_ff    <= 1'b0;
         fstart_ff <= 1'b1;
      end else if (stream_accept) begin
         ptr_ff    <= ptr_in;
         row_ff    <= row_in;
         run_ff    <= run_in;
         vis_ff    <= vis_in;
         fstart_ff <= fstart_in;
      end
   end

   // ------------------------------------------------------------------
   // palette table: write on table transfers, read with every stream byte
   // ------------------------------------------------------------------
   logic [BYTE_BITS-1:0] pal_q;

   rsbt_ram #(
      .WIDTH (BYTE_BITS),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (table_accept),
      .wr_addr (req_table_index[PAL_AW-1:0]),
      .wr_data (req_table_value),
      .rd_en   (stream_accept),
      .rd_addr (req_byte[PAL_AW-1:0]),
      .rd_data (pal_q)
   );

   // ------------------------------------------------------------------
   // stage one: stepped result, waiting for the palette data
   // ------------------------------------------------------------------
   logic                  s1_wv_ff;
   logic [OUT_ADDR_W-1:0] s1_addr_ff;
   logic [BYTE_BITS-1:0]  s1_byte_ff;
   logic                  s1_last_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (stream_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stream_accept) begin
         s1_wv_ff   <= step_wv;
         s1_addr_ff <= step_addr;
         s1_byte_ff <= req_byte;
         s1_last_ff <= req_tlast;
      end
   end

   // ------------------------------------------------------------------
   // stage two: output register
   // ------------------------------------------------------------------
   logic [BYTE_BITS-1:0]  pixel_in;
   logic                  rsp_wv_ff;
   logic [OUT_ADDR_W-1:0] rsp_addr_ff;
   logic [BYTE_BITS-1:0]  rsp_pixel_ff;
   logic                  rsp_last_ff;

   always_comb begin
      pixel_in = '0;
      if (s1_wv_ff) begin
         pixel_in = translate_enable_ff ? pal_q : s1_byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_wv_ff    <= s1_wv_ff;
         rsp_addr_ff  <= s1_addr_ff;
         rsp_pixel_ff <= pixel_in;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_pixel_ff, rsp_addr_ff};
   assign rsp_tuser  = rsp_wv_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/rsbt_ram.sv
// ----------------------------------------------------------------------------
// rsbt_ram : generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module rsbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
